FILE: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Field widths, action and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int ADDRW      = 12;  // payload and result address fields
    localparam int REQW       = 16;  // request size field
    localparam int NEEDW      = REQW + 1;  // rounded request size
    localparam int ACTW       = 2;
    localparam int STW        = 2;
    localparam int ALIGN_MASK = 7;
    localparam int MIN_TAIL   = 8;

    typedef enum logic [ACTW-1:0] {
        ACT_INIT    = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_FREE    = 2'd2,
        ACT_REALLOC = 2'd3
    } t_action;

    typedef enum logic [STW-1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_NULL  = 2'd2
    } t_status;

    typedef enum logic [11:0] {
        S_BOOT   = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_INIT   = 12'b0000_0000_0100,
        S_L_CHK  = 12'b0000_0000_1000,
        S_G_CHK  = 12'b0000_0001_0000,
        S_G_WR1  = 12'b0000_0010_0000,
        S_G_WR2  = 12'b0000_0100_0000,
        S_F_WR   = 12'b0000_1000_0000,
        S_M_CHK  = 12'b0001_0000_0000,
        S_M_NXT  = 12'b0010_0000_0000,
        S_M_EVAL = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

endpackage

FILE: rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// Header RAM
// Simple dual-port RAM with a registered read. A write to the address being
// read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Keeps an address-ordered chain of block headers in one RAM and serves
// init, allocate, free and reallocate requests by walking that chain.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake               Word contents
//  s_axis   in   s_axis_tvalid/tready    tuser: action; tdata: size, address
//  m_axis   out  m_axis_tvalid/tready    tuser: status; tdata: address
//
// A null free and a zero-size allocation go straight to the result, and init
// writes the initial header. An allocation walks the chain first-fit and writes
// the granted header, plus a tail header on a split. A free runs a locate walk,
// marks its block free and runs a merge walk from the heap base; a reallocation
// that moves its block runs the locate walk, the first-fit walk and the free.
// Every walk step is one read of the header RAM's single read port.
// After reset the initial header is written while s_axis_tready is low.
// A finished result waits in the output register; the next word is accepted
// meanwhile and its result is loaded once the previous one is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_size[15:0], payload_address[27:16]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result_address[11:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int OFFW  = $clog2(HEAP_BYTES) + 1;
    localparam int XW    = OFFW + 1;
    localparam int SZW   = $clog2(HEAP_BYTES);
    localparam int CW    = (OFFW > ADDRW) ? OFFW : ADDRW;
    // With headers a multiple of 8 bytes every header sits on an 8-byte boundary.
    localparam int GSH   = ((HEADER_BYTES % 8) == 0) ? 3 : 0;
    localparam int DEPTH = (HEAP_BYTES + (1 << GSH) - 1) >> GSH;
    localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [XW-1:0]  HB_X    = XW'(HEADER_BYTES);
    localparam logic [XW-1:0]  HEAP_X  = XW'(HEAP_BYTES);
    localparam logic [XW-1:0]  SPLIT_X = XW'(HEADER_BYTES + MIN_TAIL);
    localparam logic [SZW-1:0] INIT_SZ = SZW'(HEAP_BYTES - HEADER_BYTES);

    typedef struct packed {
        logic           free;
        logic [SZW-1:0] size;
    } t_hdr;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [ADDRW-1:0]   r_out_addr, n_out_addr;
    logic [STW-1:0]     r_out_st, n_out_st;
    t_action            r_act, n_act;
    logic [ADDRW-1:0]   r_pa, n_pa;
    logic [NEEDW-1:0]   r_need, n_need;
    logic               r_zero, n_zero;
    logic               r_re, n_re;
    logic [CW-1:0]      r_target, n_target;
    logic               r_tgt_ok, n_tgt_ok;
    logic [OFFW-1:0]    r_off, n_off;
    logic [OFFW-1:0]    r_nx, n_nx;
    t_hdr               r_cur, n_cur;
    logic [OFFW-1:0]    r_hdr, n_hdr;
    logic [SZW-1:0]     r_hsize, n_hsize;
    logic [SZW-1:0]     r_gsize, n_gsize;
    logic [ADDRW-1:0]   r_res_addr, n_res_addr;
    logic [STW-1:0]     r_res_st, n_res_st;

    t_hdr               w_rd;
    logic [1+SZW-1:0]   w_rdata;
    logic               w_we;
    logic [OFFW-1:0]    w_wr_off;
    t_hdr               w_wdata;
    logic [OFFW-1:0]    w_rd_off;
    logic               rd_sel_nx;

    t_hdr               cur;
    logic [XW-1:0]      nx_cur;
    logic               nx_end;
    logic               fit;
    logic [SZW-1:0]     rest;
    logic               split;
    logic [XW-1:0]      nb;
    logic [XW-1:0]      msize;
    logic [ADDRW-1:0]   na;
    logic               found;
    logic               out_load;

    logic [REQW-1:0]    in_req;
    logic [ADDRW-1:0]   in_pa;
    t_action            in_act;

    assign in_req = s_axis_tdata[REQW-1:0];
    assign in_pa  = s_axis_tdata[REQW +: ADDRW];
    assign in_act = t_action'(s_axis_tuser[ACTW-1:0]);

    assign w_rd = w_rdata;

    // The merge walk keeps a freshly merged header in r_cur instead of rereading it.
    assign cur    = (r_state == S_M_EVAL) ? r_cur : w_rd;
    assign nx_cur = {1'b0, r_off} + HB_X + XW'(cur.size);
    assign nx_end = (nx_cur >= HEAP_X);
    assign fit    = w_rd.free && (NEEDW'(w_rd.size) >= r_need);
    assign rest   = r_gsize - r_need[SZW-1:0];
    assign split  = (XW'(rest) >= SPLIT_X);
    assign nb     = {1'b0, r_off} + HB_X + XW'(r_need[SZW-1:0]);
    assign msize  = XW'(r_cur.size) + HB_X + XW'(w_rd.size);
    assign na     = ADDRW'({1'b0, r_off} + HB_X);
    assign found  = r_tgt_ok && (CW'(r_off) == r_target);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_addr  = r_out_addr;
        n_out_st    = r_out_st;
        n_act       = r_act;
        n_pa        = r_pa;
        n_need      = r_need;
        n_zero      = r_zero;
        n_re        = r_re;
        n_target    = r_target;
        n_tgt_ok    = r_tgt_ok;
        n_off       = r_off;
        n_nx        = r_nx;
        n_cur       = r_cur;
        n_hdr       = r_hdr;
        n_hsize     = r_hsize;
        n_gsize     = r_gsize;
        n_res_addr  = r_res_addr;
        n_res_st    = r_res_st;
        w_we        = 1'b0;
        w_wr_off    = r_off;
        w_wdata     = '{free: 1'b1, size: INIT_SZ};
        rd_sel_nx   = 1'b0;

        case (r_state)
            S_BOOT: begin
                w_we     = 1'b1;
                w_wr_off = '0;
                n_state  = S_IDLE;
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act      = in_act;
                    n_pa       = in_pa;
                    n_need     = ({1'b0, in_req} + NEEDW'(ALIGN_MASK)) & ~NEEDW'(ALIGN_MASK);
                    n_zero     = (in_req == '0);
                    n_re       = (in_act == ACT_REALLOC) && (in_pa != '0);
                    n_target   = CW'(in_pa) - CW'(HEADER_BYTES);
                    n_tgt_ok   = (CW'(in_pa) >= CW'(HEADER_BYTES));
                    n_off      = '0;
                    n_res_addr = '0;
                    n_res_st   = ST_DONE;
                    case (in_act)
                        ACT_INIT: begin
                            n_state = S_INIT;
                        end
                        ACT_FREE: begin
                            n_state = (in_pa == '0) ? S_OUT : S_L_CHK;
                        end
                        ACT_ALLOC, ACT_REALLOC: begin
                            if ((in_act == ACT_REALLOC) && (in_pa != '0)) begin
                                n_state = S_L_CHK;
                            end else if (in_req == '0) begin
                                n_res_st = ST_NULL;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_G_CHK;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_INIT: begin
                w_we     = 1'b1;
                w_wr_off = '0;
                n_state  = S_OUT;
            end

            // Locate walk: the header read for r_off is in w_rd.
            S_L_CHK: begin
                if (found) begin
                    n_hdr   = r_off;
                    n_hsize = w_rd.size;
                    if (r_act == ACT_FREE) begin
                        n_state = S_F_WR;
                    end else if (r_zero) begin
                        n_res_st = ST_NULL;
                        n_state  = S_F_WR;
                    end else if (NEEDW'(w_rd.size) >= r_need) begin
                        n_res_addr = r_pa;
                        n_state    = S_OUT;
                    end else begin
                        n_off   = '0;
                        n_state = S_G_CHK;
                    end
                end else if (nx_end) begin
                    if (r_act == ACT_FREE) begin
                        n_res_st = ST_DONE;
                    end else if (r_zero) begin
                        n_res_st = ST_NULL;
                    end else begin
                        n_res_st = ST_NOFIT;
                    end
                    n_state = S_OUT;
                end else begin
                    n_off = nx_cur[OFFW-1:0];
                end
            end

            S_G_CHK: begin
                if (fit) begin
                    n_gsize = w_rd.size;
                    n_state = S_G_WR1;
                end else if (nx_end) begin
                    n_res_addr = '0;
                    n_res_st   = ST_NOFIT;
                    n_state    = S_OUT;
                end else begin
                    n_off = nx_cur[OFFW-1:0];
                end
            end

            S_G_WR1: begin
                w_we       = 1'b1;
                w_wr_off   = r_off;
                w_wdata    = '{free: 1'b0, size: split ? r_need[SZW-1:0] : r_gsize};
                n_res_addr = na;
                n_res_st   = ST_DONE;
                if (split) begin
                    n_state = S_G_WR2;
                end else begin
                    n_state = r_re ? S_F_WR : S_OUT;
                end
            end

            S_G_WR2: begin
                w_we     = 1'b1;
                w_wr_off = nb[OFFW-1:0];
                w_wdata  = '{free: 1'b1, size: rest - SZW'(HEADER_BYTES)};
                n_state  = r_re ? S_F_WR : S_OUT;
            end

            // Mark the located block free, then start the merge walk at the heap base.
            S_F_WR: begin
                w_we     = 1'b1;
                w_wr_off = r_hdr;
                w_wdata  = '{free: 1'b1, size: r_hsize};
                n_off    = '0;
                n_state  = S_M_CHK;
            end

            S_M_CHK, S_M_EVAL: begin
                if (cur.free && !nx_end) begin
                    rd_sel_nx = 1'b1;
                    n_nx      = nx_cur[OFFW-1:0];
                    n_cur     = cur;
                    n_state   = S_M_NXT;
                end else if (nx_end) begin
                    n_state = S_OUT;
                end else begin
                    n_off   = nx_cur[OFFW-1:0];
                    n_state = S_M_CHK;
                end
            end

            // w_rd holds the neighbour at r_nx; r_cur is the free block at r_off.
            S_M_NXT: begin
                if (w_rd.free) begin
                    w_we       = 1'b1;
                    w_wr_off   = r_off;
                    w_wdata    = '{free: 1'b1, size: msize[SZW-1:0]};
                    n_cur.size = msize[SZW-1:0];
                    n_state    = S_M_EVAL;
                end else begin
                    n_off   = r_nx;
                    n_state = S_M_CHK;
                end
            end

            S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_rd_off = rd_sel_nx ? nx_cur[OFFW-1:0] : n_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr <= n_out_addr;
        r_out_st   <= n_out_st;
        r_act      <= n_act;
        r_pa       <= n_pa;
        r_need     <= n_need;
        r_zero     <= n_zero;
        r_re       <= n_re;
        r_target   <= n_target;
        r_tgt_ok   <= n_tgt_ok;
        r_off      <= n_off;
        r_nx       <= n_nx;
        r_cur      <= n_cur;
        r_hdr      <= n_hdr;
        r_hsize    <= n_hsize;
        r_gsize    <= n_gsize;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
    end

    ffha_ram #(
        .WIDTH (1 + SZW),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_off[GSH +: IDXW]),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_off[GSH +: IDXW]),
        .o_rdata (w_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - ADDRW){1'b0}}, r_out_addr};
    assign m_axis_tuser  = r_out_st;

    // Only one request is in progress at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while a request is in progress");

    // Every chain walk step looks at a header inside the heap.
    a_walk_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_L_CHK) || (r_state == S_G_CHK) || (r_state == S_M_CHK))
        |-> ({1'b0, r_off} < HEAP_X))
        else $error("chain walk left the heap");

    // Loading a result shows it at the output and frees the sequencer.
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (m_axis_tvalid && (r_state == S_IDLE)))
        else $error("result load did not complete");

    // A failed or zero-size request never returns an address.
    a_null_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> (m_axis_tdata == '0))
        else $error("non-null address with a failure status");

endmodule

FILE: tb/first_fit_heap_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives init, allocate, free and reallocate words into the allocator. It
// keeps its own copy of the header chain to predict each result word and
// compares every result with the oldest prediction. A directed table comes
// first, then random traffic made mostly of frees and reallocations of live
// blocks. Both stream sides idle at random in several phases.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test;
    import ffha_pkg::*;

    localparam int HEAP_BYTES      = 4096;
    localparam int HEADER_BYTES    = 24;
    localparam int RANDOM_WORDS    = 800;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int TAIL_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_ROWS   = 25;

    typedef struct packed {
        t_action             action;
        logic [REQW-1:0]     size;
        logic [ADDRW-1:0]    addr;
    } t_request;

    typedef struct packed {
        logic [ADDRW-1:0]    addr;
        t_status             status;
    } t_grant;

    typedef struct packed {
        t_action             action;
        logic [REQW-1:0]     size;
        logic [ADDRW-1:0]    addr;
        logic                fixed;      // expectation typed into the row
        logic [ADDRW-1:0]    want_addr;
        t_status             want_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // request_size[15:0], payload_address[27:16]
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // result_address[11:0]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // Shadow of the header chain.
    int unsigned blk_size [HEAP_BYTES];
    bit          blk_free [HEAP_BYTES];

    t_grant      pending_grants [$];
    int          fault_count;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off_req;
    logic        row_fixed;
    t_grant      row_want;

    // Rows up to the grow case follow the chain built from the first init.
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{ACT_ALLOC,   16'd0,     12'd0,    1'b1, 12'd0,  ST_NULL},
        '{ACT_ALLOC,   16'd65535, 12'd0,    1'b1, 12'd0,  ST_NOFIT},
        '{ACT_ALLOC,   16'd4072,  12'd0,    1'b1, 12'd24, ST_DONE},
        '{ACT_ALLOC,   16'd1,     12'd0,    1'b1, 12'd0,  ST_NOFIT},
        '{ACT_FREE,    16'd0,     12'd24,   1'b1, 12'd0,  ST_DONE},
        '{ACT_FREE,    16'd0,     12'd0,    1'b1, 12'd0,  ST_DONE},
        '{ACT_INIT,    16'd65535, 12'd4095, 1'b1, 12'd0,  ST_DONE},
        '{ACT_ALLOC,   16'd1,     12'd0,    1'b1, 12'd24, ST_DONE},
        '{ACT_ALLOC,   16'd8,     12'd0,    1'b1, 12'd56, ST_DONE},
        '{ACT_ALLOC,   16'd4009,  12'd0,    1'b1, 12'd0,  ST_NOFIT},
        '{ACT_ALLOC,   16'd4008,  12'd0,    1'b1, 12'd88, ST_DONE},
        '{ACT_FREE,    16'd0,     12'd57,   1'b1, 12'd0,  ST_DONE},
        '{ACT_REALLOC, 16'd0,     12'd4095, 1'b1, 12'd0,  ST_NULL},
        '{ACT_REALLOC, 16'd5,     12'd100,  1'b1, 12'd0,  ST_NOFIT},
        '{ACT_REALLOC, 16'd8,     12'd56,   1'b1, 12'd56, ST_DONE},
        '{ACT_REALLOC, 16'd16,    12'd24,   1'b1, 12'd0,  ST_NOFIT},
        '{ACT_FREE,    16'd0,     12'd56,   1'b0, 12'd0,  ST_DONE},
        '{ACT_FREE,    16'd0,     12'd56,   1'b0, 12'd0,  ST_DONE},
        '{ACT_REALLOC, 16'd8,     12'd56,   1'b0, 12'd0,  ST_DONE},
        '{ACT_REALLOC, 16'd3,     12'd0,    1'b0, 12'd0,  ST_DONE},
        '{ACT_FREE,    16'd0,     12'd88,   1'b0, 12'd0,  ST_DONE},
        '{ACT_REALLOC, 16'd100,   12'd24,   1'b0, 12'd0,  ST_DONE},
        '{ACT_REALLOC, 16'd0,     12'd56,   1'b1, 12'd0,  ST_NULL},
        '{ACT_REALLOC, 16'd0,     12'd0,    1'b1, 12'd0,  ST_NULL},
        '{ACT_INIT,    16'd0,     12'd0,    1'b1, 12'd0,  ST_DONE}
    };

    first_fit_heap_allocator #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Heap predictor
    // ------------------------------------------------------------------------
    function automatic void heap_rebuild();
        foreach (blk_size[i]) begin
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
        end
        blk_size[0] = HEAP_BYTES - HEADER_BYTES;
        blk_free[0] = 1'b1;
    endfunction

    function automatic int unsigned align8(logic [REQW-1:0] size);
        return ({16'd0, size} + ALIGN_MASK) & ~ALIGN_MASK;
    endfunction

    // Header offset of the block whose payload starts at addr, or HEAP_BYTES.
    function automatic int unsigned header_of(logic [ADDRW-1:0] addr);
        int unsigned off;
        int unsigned target;
        int unsigned steps;
        off = 0;
        steps = 0;
        if (addr < HEADER_BYTES)
            return HEAP_BYTES;
        target = addr - HEADER_BYTES;
        while (off < HEAP_BYTES && steps < HEAP_BYTES) begin
            if (off == target)
                return off;
            off = off + HEADER_BYTES + blk_size[off];
            steps++;
        end
        return HEAP_BYTES;
    endfunction

    function automatic int unsigned carve_first_fit(int unsigned need);
        int unsigned off;
        int unsigned steps;
        int unsigned rest;
        int unsigned tail;
        off = 0;
        steps = 0;
        while (off < HEAP_BYTES && steps < HEAP_BYTES) begin
            if (blk_free[off] && blk_size[off] >= need) begin
                rest = blk_size[off] - need;
                if (rest >= HEADER_BYTES + MIN_TAIL) begin
                    tail = off + HEADER_BYTES + need;
                    if (tail < HEAP_BYTES) begin
                        blk_size[tail] = rest - HEADER_BYTES;
                        blk_free[tail] = 1'b1;
                        blk_size[off]  = need;
                    end
                end
                blk_free[off] = 1'b0;
                return off + HEADER_BYTES;
            end
            off = off + HEADER_BYTES + blk_size[off];
            steps++;
        end
        return 0;
    endfunction

    // Marks the block free, then merges every adjacent pair of free blocks.
    function automatic void release_block(int unsigned hdr);
        int unsigned off;
        int unsigned nxt;
        int unsigned steps;
        if (hdr >= HEAP_BYTES)
            return;
        blk_free[hdr] = 1'b1;
        off = 0;
        steps = 0;
        while (off < HEAP_BYTES && steps < 2 * HEAP_BYTES) begin
            nxt = off + HEADER_BYTES + blk_size[off];
            if (blk_free[off] && nxt < HEAP_BYTES && blk_free[nxt])
                blk_size[off] += HEADER_BYTES + blk_size[nxt];
            else
                off = nxt;
            steps++;
        end
    endfunction

    function automatic t_grant alloc_payload(logic [REQW-1:0] size);
        t_grant      res;
        int unsigned granted;
        res.addr = '0;
        res.status = ST_NULL;
        if (size == 0)
            return res;
        granted = carve_first_fit(align8(size));
        res.addr = granted[ADDRW-1:0];
        res.status = (granted != 0) ? ST_DONE : ST_NOFIT;
        return res;
    endfunction

    function automatic t_grant serve_request(t_request r);
        t_grant      res;
        int unsigned hdr;
        int unsigned granted;
        res.addr = '0;
        res.status = ST_DONE;
        case (r.action)
            ACT_INIT: heap_rebuild();
            ACT_ALLOC: res = alloc_payload(r.size);
            ACT_FREE: begin
                if (r.addr != 0)
                    release_block(header_of(r.addr));
            end
            default: begin
                if (r.addr == 0) begin
                    res = alloc_payload(r.size);
                end else begin
                    hdr = header_of(r.addr);
                    if (r.size == 0) begin
                        release_block(hdr);
                        res.status = ST_NULL;
                    end else if (hdr >= HEAP_BYTES) begin
                        res.status = ST_NOFIT;
                    end else if (blk_size[hdr] >= align8(r.size)) begin
                        // Kept in place, even when the block is marked free.
                        res.addr = r.addr;
                    end else begin
                        granted = carve_first_fit(align8(r.size));
                        if (granted == 0) begin
                            res.status = ST_NOFIT;
                        end else begin
                            release_block(hdr);
                            res.addr = granted[ADDRW-1:0];
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Payload address of a random block on the chain, or null if none fits.
    function automatic logic [ADDRW-1:0] pick_chain_address(bit only_used);
        int unsigned      off;
        int unsigned      steps;
        logic [ADDRW-1:0] found [$];
        off = 0;
        steps = 0;
        while (off < HEAP_BYTES && steps < HEAP_BYTES) begin
            if (!only_used || !blk_free[off])
                found.push_back(ADDRW'(off + HEADER_BYTES));
            off = off + HEADER_BYTES + blk_size[off];
            steps++;
        end
        if (found.size() == 0)
            return '0;
        return found[$urandom_range(found.size() - 1)];
    endfunction

    function automatic logic [REQW-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return REQW'($urandom_range(64, 1));
        else if (r < 82)
            return REQW'($urandom_range(512, 65));
        else if (r < 92)
            return REQW'($urandom_range(HEAP_BYTES - HEADER_BYTES, 513));
        else if (r < 96)
            return REQW'($urandom_range(HEAP_BYTES - 16, HEAP_BYTES - 31));
        return REQW'($urandom_range(65535, 0));
    endfunction

    function automatic logic [ADDRW-1:0] pick_target();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 15)
            return pick_chain_address(1'b1);
        else if (r < 17)
            return pick_chain_address(1'b0);
        else if (r == 17)
            return '0;
        return ADDRW'($urandom());
    endfunction

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endfunction

    // Called at a falling edge; returns at the rising edge that takes the word.
    task automatic send_word(t_request r, logic fixed, t_grant want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        row_fixed     = fixed;
        row_want      = want;
        s_axis_tdata  = {4'd0, r.addr, r.size};
        s_axis_tuser  = r.action;
        s_axis_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_grants.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor, scoreboard and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_request seen;
        t_grant   predicted;
        t_grant   oldest;
        if (i_rst_n) begin
            // The result leaving now belongs to an earlier word, so check first.
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_grants.size() == 0) begin
                    note_fault($sformatf("result word with none expected: addr %0d status %0d",
                                         m_axis_tdata[ADDRW-1:0], m_axis_tuser));
                end else begin
                    oldest = pending_grants.pop_front();
                    if (m_axis_tdata[ADDRW-1:0] !== oldest.addr
                            || m_axis_tuser !== oldest.status)
                        note_fault($sformatf(
                            "mismatch: expected addr %0d status %s, got addr %0d status %0d",
                            oldest.addr, oldest.status.name(),
                            m_axis_tdata[ADDRW-1:0], m_axis_tuser));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.action = t_action'(s_axis_tuser);
                seen.size   = s_axis_tdata[15:0];
                seen.addr   = s_axis_tdata[27:16];
                predicted   = serve_request(seen);
                pending_grants.push_back(row_fixed ? row_want : predicted);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_request req;
        t_grant   none;
        int       phase;
        int       r;
        none.addr      = '0;
        none.status    = ST_DONE;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_INIT;
        row_fixed      = 1'b0;
        row_want       = none;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;
        fault_count    = 0;
        quiet_cycles   = 0;
        heap_rebuild();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            @(negedge i_clk);
            req.action = directed_rows[i].action;
            req.size   = directed_rows[i].size;
            req.addr   = directed_rows[i].addr;
            send_word(req, directed_rows[i].fixed,
                      '{directed_rows[i].want_addr, directed_rows[i].want_status});
        end
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            phase = (n / 100) % 4;
            send_idle_pct  = (phase == 1) ? 58 : (phase == 3) ? 13 : 0;
            recv_stall_pct = (phase == 2) ? 58 : (phase == 3) ? 13 : 0;
            // Long result stall while words keep coming, so the input backs up.
            if (n == 20)
                hold_off_req = 1'b1;
            if (n == 450)
                wait_drained();
            @(negedge i_clk);
            // Unused fields carry noise; the block must ignore them.
            req.size = REQW'($urandom());
            req.addr = ADDRW'($urandom());
            r = $urandom_range(99);
            if (r < 2) begin
                req.action = ACT_INIT;
            end else if (r < 42) begin
                req.action = ACT_ALLOC;
                req.size   = ($urandom_range(49) == 0) ? '0 : pick_size();
            end else if (r < 70) begin
                req.action = ACT_FREE;
                req.addr   = pick_target();
            end else begin
                req.action = ACT_REALLOC;
                req.addr   = pick_target();
                req.size   = ($urandom_range(99) < 12) ? '0 : pick_size();
            end
            send_word(req, 1'b0, none);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_grants.size() != 0)
            note_fault($sformatf("%0d result words never arrived", pending_grants.size()));
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_test.sv
